### sv/ppp_pkg.sv
// ppp_pkg: shared types and constants for the perspective point projection block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ppp_pkg;

	// Quotient bits kept by the divider chain; a larger quotient saturates.
	localparam int Q_W = 50;
	// Width of |clip| * (size << (FRAC_BITS-1)); independent of FRAC_BITS.
	localparam int NUM_W = 79;
	// Width of the final screen sums before clamping.
	localparam int SUM_W = 54;
	// Register count and register indexes of the configuration port.
	localparam int REG_N = 8;
	localparam logic [2:0] REG_VP_SIZE   = 3'd6;
	localparam logic [2:0] REG_VP_ORIGIN = 3'd7;

	// Per-transaction control carried alongside the divider data.
	typedef struct packed {
		logic valid;
		logic visible;
		logic neg_x;
		logic neg_y;
		logic sat_x;
		logic sat_y;
	} ppp_side_t;

endpackage

### sv/ppp_transform.sv
// ppp_transform: three-stage matrix-row by point transform giving clip x, y and w.
// Depends on ppp_pkg.
`timescale 1ns / 1ps

module ppp_transform #(
	parameter int FRAC_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic signed [31:0]         point_x,
	input  logic signed [31:0]         point_y,
	input  logic signed [31:0]         point_z,
	input  logic [63:0]                coef [6],
	output logic                       valid_s3,
	output logic signed [64-FRAC_BITS:0] row_s3 [3]
);
	import ppp_pkg::*;

	localparam int ROW_W = 65 - FRAC_BITS;

	logic                    valid_s1, valid_s2;
	logic signed [63:0]      prod_s1 [9];
	logic signed [ROW_W-1:0] pa_s2 [3];
	logic signed [ROW_W-1:0] pb_s2 [3];
	logic signed [63:0]      pa_c [3];
	logic signed [63:0]      pb_c [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			pa_c[r] = (prod_s1[3*r] >>> FRAC_BITS) + (prod_s1[3*r+1] >>> FRAC_BITS);
			pb_c[r] = (prod_s1[3*r+2] >>> FRAC_BITS)
				+ 64'($signed(coef[2*r+1][63:32]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				prod_s1[3*r]   <= 64'($signed(coef[2*r][31:0])) * 64'(point_x);
				prod_s1[3*r+1] <= 64'($signed(coef[2*r][63:32])) * 64'(point_y);
				prod_s1[3*r+2] <= 64'($signed(coef[2*r+1][31:0])) * 64'(point_z);
				pa_s2[r]       <= pa_c[r][ROW_W-1:0];
				pb_s2[r]       <= pb_c[r][ROW_W-1:0];
				row_s3[r]      <= pa_s2[r] + pb_s2[r];
			end
		end
	end

endmodule

### sv/ppp_div_cell.sv
// ppp_div_cell: one restoring-division step for the x and y lanes, registered.
// Depends on ppp_pkg.
`timescale 1ns / 1ps

module ppp_div_cell #(
	parameter int MAG_W = 48
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  ppp_pkg::ppp_side_t           side_in,
	input  logic [MAG_W-1:0]             div_in,
	input  logic [MAG_W-1:0]             rem_x_in,
	input  logic [MAG_W-1:0]             rem_y_in,
	input  logic [ppp_pkg::Q_W-1:0]      lo_x_in,
	input  logic [ppp_pkg::Q_W-1:0]      lo_y_in,
	input  logic [ppp_pkg::Q_W-1:0]      q_x_in,
	input  logic [ppp_pkg::Q_W-1:0]      q_y_in,
	output ppp_pkg::ppp_side_t           side_q,
	output logic [MAG_W-1:0]             div_q,
	output logic [MAG_W-1:0]             rem_x_q,
	output logic [MAG_W-1:0]             rem_y_q,
	output logic [ppp_pkg::Q_W-1:0]      lo_x_q,
	output logic [ppp_pkg::Q_W-1:0]      lo_y_q,
	output logic [ppp_pkg::Q_W-1:0]      q_x_q,
	output logic [ppp_pkg::Q_W-1:0]      q_y_q
);
	import ppp_pkg::*;

	logic [MAG_W:0] trial_x, trial_y, dext;
	logic           ge_x, ge_y;
	logic [MAG_W:0] diff_x, diff_y;

	always_comb begin
		dext    = {1'b0, div_in};
		trial_x = {rem_x_in, lo_x_in[Q_W-1]};
		trial_y = {rem_y_in, lo_y_in[Q_W-1]};
		ge_x    = trial_x >= dext;
		ge_y    = trial_y >= dext;
		diff_x  = ge_x ? trial_x - dext : trial_x;
		diff_y  = ge_y ? trial_y - dext : trial_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= '0;
		end else if (en) begin
			side_q <= side_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_q   <= div_in;
			rem_x_q <= diff_x[MAG_W-1:0];
			rem_y_q <= diff_y[MAG_W-1:0];
			lo_x_q  <= {lo_x_in[Q_W-2:0], 1'b0};
			lo_y_q  <= {lo_y_in[Q_W-2:0], 1'b0};
			q_x_q   <= {q_x_in[Q_W-2:0], ge_x};
			q_y_q   <= {q_y_in[Q_W-2:0], ge_y};
		end
	end

endmodule

### sv/ppp_viewport.sv
// ppp_viewport: adds viewport offsets to the divided terms, clamps, and holds the result.
// Depends on ppp_pkg.
`timescale 1ns / 1ps

module ppp_viewport #(
	parameter int FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  ppp_pkg::ppp_side_t      side_in,
	input  logic [ppp_pkg::Q_W-1:0] q_x_in,
	input  logic [ppp_pkg::Q_W-1:0] q_y_in,
	input  logic [31:0]             vp_size,
	input  logic [31:0]             vp_origin,
	output logic                    valid_q,
	output logic                    visible_q,
	output logic signed [31:0]      screen_x_q,
	output logic signed [31:0]      screen_y_q
);
	import ppp_pkg::*;

	localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [SUM_W-1:0] SMAX = SUM_W'(32'h7fff_ffff);
	localparam logic signed [SUM_W-1:0] SMIN = -(SUM_W'(1) <<< 31);

	logic signed [SUM_W-1:0] mag_x, mag_y, term_x, term_y;
	logic signed [SUM_W-1:0] base_x, base_y, org_x, org_y, sum_x, sum_y;
	logic signed [31:0]      clamp_x, clamp_y;

	always_comb begin
		mag_x  = side_in.sat_x ? (SUM_W'(1) <<< Q_W) : SUM_W'(q_x_in);
		mag_y  = side_in.sat_y ? (SUM_W'(1) <<< Q_W) : SUM_W'(q_y_in);
		term_x = side_in.neg_x ? -mag_x : mag_x;
		term_y = side_in.neg_y ? -mag_y : mag_y;
		base_x = SUM_W'(vp_size[15:1]) <<< FRAC_BITS;
		base_y = SUM_W'(vp_size[31:17]) <<< FRAC_BITS;
		org_x  = SUM_W'($signed(vp_origin[15:0])) <<< FRAC_BITS;
		org_y  = SUM_W'($signed(vp_origin[31:16])) <<< FRAC_BITS;
		sum_x  = base_x + term_x + HALF + org_x;
		sum_y  = base_y - term_y - HALF + org_y;
		if (sum_x > SMAX)      clamp_x = SMAX[31:0];
		else if (sum_x < SMIN) clamp_x = SMIN[31:0];
		else                   clamp_x = sum_x[31:0];
		if (sum_y > SMAX)      clamp_y = SMAX[31:0];
		else if (sum_y < SMIN) clamp_y = SMIN[31:0];
		else                   clamp_y = sum_y[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= side_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			visible_q  <= side_in.visible;
			screen_x_q <= side_in.visible ? clamp_x : '0;
			screen_y_q <= side_in.visible ? clamp_y : '0;
		end
	end

endmodule

### sv/perspective_point_projection.sv
// perspective_point_projection: top level with register file, divider setup and cell chain.
// Depends on ppp_pkg, ppp_transform, ppp_div_cell and ppp_viewport.
`timescale 1ns / 1ps

//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  point in  | in_valid, in_stall, point_x/y/z           | input
//  result    | out_valid, out_stall, visible, screen_x/y | output
//  config    | psel, penable, pwrite, paddr, pwdata, ... | input
//
// One transaction enters every cycle while the pipeline is not held; the path is three
// transform stages, two divider setup stages, 50 divider cells and one output register.
// Most of the pipeline is the 50-cell restoring divider, one quotient bit per cell.
// Reset clears the configuration registers and all valid flags; no clearing pass is needed.
// The whole pipeline holds while a result waits under out_stall, so in_stall
// follows out_stall only when the output register is full.

module perspective_point_projection #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               visible,
	output logic signed [31:0] screen_x,
	output logic signed [31:0] screen_y,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready
);
	import ppp_pkg::*;

	localparam int ROW_W = 65 - FRAC_BITS;
	localparam int MAG_W = 64 - FRAC_BITS;
	localparam int SZ_W  = 15 + FRAC_BITS;
	// Visibility threshold in raw units: ceil(0.01 * 2^FRAC_BITS).
	localparam logic signed [ROW_W-1:0] THR = ROW_W'(((1 << FRAC_BITS) / 100) + 1);

	// Configuration registers; the size and origin words keep 32 bits.
	logic [63:0] cfg_q [REG_N];
	logic [2:0]  widx;

	assign pready = 1'b1;
	assign widx   = paddr[5:3];
	assign prdata = cfg_q[widx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_N; i++) cfg_q[i] <= '0;
		end else if (psel && penable && pwrite && pready) begin
			if (widx == REG_VP_SIZE || widx == REG_VP_ORIGIN) begin
				cfg_q[widx] <= {32'd0, pwdata[31:0]};
			end else begin
				cfg_q[widx] <= pwdata;
			end
		end
	end

	// Global advance: everything moves unless a finished result is held.
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	logic [63:0] coef [6];
	always_comb begin
		for (int i = 0; i < 6; i++) coef[i] = cfg_q[i];
	end

	logic                    valid_s3;
	logic signed [ROW_W-1:0] row_s3 [3];

	ppp_transform #(.FRAC_BITS(FRAC_BITS)) u_xform (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.point_x  (point_x),
		.point_y  (point_y),
		.point_z  (point_z),
		.coef     (coef),
		.valid_s3 (valid_s3),
		.row_s3   (row_s3)
	);

	// Stage 4: visibility, signs and numerators |c| * (size << (FRAC_BITS-1)).
	logic [ROW_W-1:0] absx_c, absy_c;
	logic [SZ_W-1:0]  szw_c, szh_c;
	logic             valid_s4, visible_s4, negx_s4, negy_s4;
	logic [NUM_W-1:0] numx_s4, numy_s4;
	logic [MAG_W-1:0] w_s4;

	always_comb begin
		absx_c = row_s3[0][ROW_W-1] ? ROW_W'(-row_s3[0]) : ROW_W'(row_s3[0]);
		absy_c = row_s3[1][ROW_W-1] ? ROW_W'(-row_s3[1]) : ROW_W'(row_s3[1]);
		szw_c  = SZ_W'(cfg_q[REG_VP_SIZE][15:0]) << (FRAC_BITS - 1);
		szh_c  = SZ_W'(cfg_q[REG_VP_SIZE][31:16]) << (FRAC_BITS - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			visible_s4 <= row_s3[2] >= THR;
			negx_s4    <= row_s3[0][ROW_W-1];
			negy_s4    <= row_s3[1][ROW_W-1];
			numx_s4    <= NUM_W'(absx_c[MAG_W-1:0]) * NUM_W'(szw_c);
			numy_s4    <= NUM_W'(absy_c[MAG_W-1:0]) * NUM_W'(szh_c);
			w_s4       <= row_s3[2][MAG_W-1:0];
		end
	end

	// Stage 5: saturation test on the high numerator part, which seeds the remainder.
	logic [MAG_W-1:0] hix_c, hiy_c;
	assign hix_c = MAG_W'(numx_s4[NUM_W-1:Q_W]);
	assign hiy_c = MAG_W'(numy_s4[NUM_W-1:Q_W]);

	ppp_side_t        side_c [Q_W+1];
	logic [MAG_W-1:0] div_c  [Q_W+1];
	logic [MAG_W-1:0] remx_c [Q_W+1];
	logic [MAG_W-1:0] remy_c [Q_W+1];
	logic [Q_W-1:0]   lox_c  [Q_W+1];
	logic [Q_W-1:0]   loy_c  [Q_W+1];
	logic [Q_W-1:0]   qx_c   [Q_W+1];
	logic [Q_W-1:0]   qy_c   [Q_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_c[0] <= '0;
		end else if (en) begin
			side_c[0] <= '{valid: valid_s4, visible: visible_s4, neg_x: negx_s4,
				neg_y: negy_s4, sat_x: hix_c >= w_s4, sat_y: hiy_c >= w_s4};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_c[0]  <= w_s4;
			remx_c[0] <= hix_c;
			remy_c[0] <= hiy_c;
			lox_c[0]  <= numx_s4[Q_W-1:0];
			loy_c[0]  <= numy_s4[Q_W-1:0];
			qx_c[0]   <= '0;
			qy_c[0]   <= '0;
		end
	end

	// Chain of division cells, one quotient bit per cell for both lanes.
	for (genvar j = 0; j < Q_W; j++) begin : g_cell
		ppp_div_cell #(.MAG_W(MAG_W)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.side_in  (side_c[j]),
			.div_in   (div_c[j]),
			.rem_x_in (remx_c[j]),
			.rem_y_in (remy_c[j]),
			.lo_x_in  (lox_c[j]),
			.lo_y_in  (loy_c[j]),
			.q_x_in   (qx_c[j]),
			.q_y_in   (qy_c[j]),
			.side_q   (side_c[j+1]),
			.div_q    (div_c[j+1]),
			.rem_x_q  (remx_c[j+1]),
			.rem_y_q  (remy_c[j+1]),
			.lo_x_q   (lox_c[j+1]),
			.lo_y_q   (loy_c[j+1]),
			.q_x_q    (qx_c[j+1]),
			.q_y_q    (qy_c[j+1])
		);
	end

	ppp_viewport #(.FRAC_BITS(FRAC_BITS)) u_vp (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.side_in    (side_c[Q_W]),
		.q_x_in     (qx_c[Q_W]),
		.q_y_in     (qy_c[Q_W]),
		.vp_size    (cfg_q[REG_VP_SIZE][31:0]),
		.vp_origin  (cfg_q[REG_VP_ORIGIN][31:0]),
		.valid_q    (out_valid),
		.visible_q  (visible),
		.screen_x_q (screen_x),
		.screen_y_q (screen_y)
	);

endmodule

### verif/tb.sv
// tb: self-checking testbench for perspective_point_projection.
// Depends on ppp_pkg and the block's RTL; predicts every result in place and
// compares each one as it leaves the block.
`timescale 1ns / 1ps

module tb;
	import ppp_pkg::*;

	localparam int FRAC = 16;
	localparam int LATENCY = 56;
	localparam int RANDOM_POINTS = 1400;
	localparam longint CYCLE_LIMIT = 400000;

	// Register indexes on the configuration port, at byte address 8*i.
	typedef enum logic [2:0] {
		IDX_ROW0_01 = 3'd0,
		IDX_ROW0_23 = 3'd1,
		IDX_ROW1_01 = 3'd2,
		IDX_ROW1_23 = 3'd3,
		IDX_ROW3_01 = 3'd4,
		IDX_ROW3_23 = 3'd5,
		IDX_VP_SIZE = 3'd6,
		IDX_VP_ORIGIN = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic visible;
		logic signed [31:0] sx;
		logic signed [31:0] sy;
	} screen_pt_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;
	logic out_valid;
	logic out_stall;
	logic visible;
	logic signed [31:0] screen_x;
	logic signed [31:0] screen_y;
	logic psel;
	logic penable;
	logic pwrite;
	logic [5:0] paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic pready;

	perspective_point_projection #(.FRAC_BITS(FRAC)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.visible(visible), .screen_x(screen_x), .screen_y(screen_y),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Local copy of the register file, used by the projection predictor.
	logic [63:0] matrix_regs [0:7];

	// Projections still owed by the block, oldest first.
	screen_pt_t pending_points[$];

	int errors = 0;
	longint cycle_count = 0;
	// When set, the result side refuses everything (long hold-off).
	bit hold_results = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Run guard: a run that needs far longer than the slowest correct one is hung.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic logic signed [63:0] coef_of(int r, bit upper);
		logic [31:0] w;
		w = upper ? matrix_regs[r][63:32] : matrix_regs[r][31:0];
		return {{32{w[31]}}, w};
	endfunction

	// One matrix row dotted with the point: each product floored to FRAC
	// fraction bits, then summed exactly with the translation coefficient.
	function automatic logic signed [63:0] row_dot(int r, logic signed [31:0] px,
			logic signed [31:0] py, logic signed [31:0] pz);
		logic signed [63:0] acc;
		acc = (coef_of(r, 0) * 64'(px)) >>> FRAC;
		acc += (coef_of(r, 1) * 64'(py)) >>> FRAC;
		acc += (coef_of(r + 1, 0) * 64'(pz)) >>> FRAC;
		acc += coef_of(r + 1, 1);
		return acc;
	endfunction

	// |c| * size * 2^(FRAC-1) / w, truncated toward zero and capped at 2^50.
	function automatic logic signed [63:0] viewport_offset(logic signed [63:0] c,
			logic [15:0] size, logic signed [63:0] w);
		logic [127:0] num;
		logic [127:0] quo;
		logic [63:0] mag;
		mag = c < 0 ? -c : c;
		num = 128'(mag) * 128'(size) << (FRAC - 1);
		quo = num / 128'(w);
		if (quo > (128'd1 << 50)) quo = 128'd1 << 50;
		return c < 0 ? -64'(quo) : 64'(quo);
	endfunction

	function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic screen_pt_t project_point(logic signed [31:0] px,
			logic signed [31:0] py, logic signed [31:0] pz);
		screen_pt_t res;
		logic signed [63:0] cx, cy, cw, sx, sy, half, thr, left, top;
		logic [15:0] wid, hgt;
		half = 64'sd1 <<< (FRAC - 1);
		thr = ((64'sd1 <<< FRAC) / 100) + 1;
		cx = row_dot(0, px, py, pz);
		cy = row_dot(2, px, py, pz);
		cw = row_dot(4, px, py, pz);
		wid = matrix_regs[IDX_VP_SIZE][15:0];
		hgt = matrix_regs[IDX_VP_SIZE][31:16];
		left = {{48{matrix_regs[IDX_VP_ORIGIN][15]}}, matrix_regs[IDX_VP_ORIGIN][15:0]};
		top = {{48{matrix_regs[IDX_VP_ORIGIN][31]}}, matrix_regs[IDX_VP_ORIGIN][31:16]};
		res = '0;
		if (cw < thr) return res;
		sx = (64'(wid >> 1) <<< FRAC) + viewport_offset(cx, wid, cw) + half + (left <<< FRAC);
		sy = (64'(hgt >> 1) <<< FRAC) - viewport_offset(cy, hgt, cw) - half + (top <<< FRAC);
		res.visible = 1'b1;
		res.sx = clamp32(sx);
		res.sy = clamp32(sy);
		return res;
	endfunction

	// Setup then access phase; the register takes the value on the access edge.
	// The bus then goes idle so that back-to-back writes never overlap.
	task automatic write_reg(reg_idx_t idx, logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		matrix_regs[idx] = (idx >= IDX_VP_SIZE) ? {32'd0, value[31:0]} : value;
	endtask

	// Block is idle: nothing owed, then quiet cycles to let the pipeline run empty.
	task automatic drain_pipeline();
		while (pending_points.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// Offers one point and holds it until it is taken. A random gap may come
	// first, so the sender works in bursts.
	task automatic send_point(logic signed [31:0] px, logic signed [31:0] py,
			logic signed [31:0] pz, bit gaps);
		if (gaps && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		point_x <= px;
		point_y <= py;
		point_z <= pz;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_points.push_back(project_point(px, py, pz));
	endtask

	task automatic go_quiet();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return $urandom();
			1: return 32'h80000000;
			2: return 32'h7fffffff;
			default: return $urandom_range(0, 32'h00140000) - 32'h000a0000;
		endcase
	endfunction

	// Mostly a sane camera (small coefficients, positive w), sometimes extremes.
	function automatic logic [31:0] rand_coef(bit w_bias);
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return 32'h80000000;
			2: return 32'h7fffffff;
			default: return w_bias ? $urandom_range(0, 32'h00040000)
				: $urandom_range(0, 32'h00040000) - 32'h00020000;
		endcase
	endfunction

	// Receiver stall pattern: a phase-varying duty cycle, some clean
	// stretches, and a long hold-off on request.
	initial begin : result_side
		int stall_pct;
		out_stall <= 1'b0;
		stall_pct = 0;
		forever begin
			@(posedge clk);
			if (cycle_count % 300 == 0) stall_pct = $urandom_range(0, 3) * 20;
			out_stall <= hold_results || ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Result checker: every accepted transaction against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_points.size() == 0) begin
				$error("result with no point outstanding");
				errors++;
			end else begin
				screen_pt_t want;
				want = pending_points.pop_front();
				if (visible !== want.visible) begin
					$error("visible: expected %0d actual %0d", want.visible, visible);
					errors++;
				end
				if (screen_x !== want.sx) begin
					$error("screen_x: expected %0d actual %0d", want.sx, screen_x);
					errors++;
				end
				if (screen_y !== want.sy) begin
					$error("screen_y: expected %0d actual %0d", want.sy, screen_y);
					errors++;
				end
			end
		end
	end

	// Directed table. A zero check flag means the row is checked by the
	// predictor only; with it set, the typed-in answer must also agree.
	typedef struct {
		logic [31:0] px, py, pz;
		bit check;
		screen_pt_t answer;
	} directed_row_t;

	initial begin : stimulus
		directed_row_t rows[$];
		int n;
		in_valid <= 1'b0;
		point_x <= '0;
		point_y <= '0;
		point_z <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		for (int i = 0; i < 8; i++) matrix_regs[i] = '0;
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset every register is zero: w is zero, so nothing is visible.
		rows.push_back('{32'h7fffffff, 32'h80000000, 32'h00010000, 1, '0});
		rows.push_back('{32'h80000000, 32'h7fffffff, 32'hffffffff, 1, '0});
		foreach (rows[i]) send_point(rows[i].px, rows[i].py, rows[i].pz, 0);
		go_quiet();
		foreach (rows[i])
			if (rows[i].check && project_point(rows[i].px, rows[i].py, rows[i].pz) != rows[i].answer) begin
				$error("directed row %0d answer disagrees with prediction", i);
				errors++;
			end
		drain_pipeline();

		// Identity-like camera: w = 1.0 translation, 640x480 viewport.
		write_reg(IDX_ROW0_01, {32'h0, 32'h00010000});
		write_reg(IDX_ROW0_23, {32'h0, 32'h0});
		write_reg(IDX_ROW1_01, {32'h0, 32'h00010000} << 32);
		write_reg(IDX_ROW1_23, 64'h0);
		write_reg(IDX_ROW3_01, 64'h0);
		write_reg(IDX_ROW3_23, {32'h00010000, 32'h0});
		write_reg(IDX_VP_SIZE, {16'd480, 16'd640});
		write_reg(IDX_VP_ORIGIN, {16'hfff0, 16'h0010});
		rows.delete();
		rows.push_back('{32'h0, 32'h0, 32'h0, 0, '0});
		rows.push_back('{32'h00010000, 32'hffff0000, 32'h0, 0, '0});
		rows.push_back('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, '0});
		rows.push_back('{32'h80000000, 32'h80000000, 32'h80000000, 0, '0});
		rows.push_back('{32'h00008000, 32'hffff8000, 32'h12345678, 0, '0});
		foreach (rows[i]) send_point(rows[i].px, rows[i].py, rows[i].pz, 0);
		go_quiet();
		drain_pipeline();

		// w driven by z: threshold edges, negative w, and a zero viewport.
		write_reg(IDX_ROW3_01, 64'h0);
		write_reg(IDX_ROW3_23, {32'h0, 32'h00010000});
		rows.delete();
		rows.push_back('{32'h00010000, 32'h00010000, 32'd655, 1, '0});
		rows.push_back('{32'h00010000, 32'h00010000, 32'd656, 0, '0});
		rows.push_back('{32'h00010000, 32'h00010000, 32'd657, 0, '0});
		rows.push_back('{32'h7fffffff, 32'h80000000, 32'd656, 0, '0});
		rows.push_back('{32'h00010000, 32'h00010000, 32'hffff0000, 1, '0});
		rows.push_back('{32'h80000000, 32'h7fffffff, 32'h80000000, 1, '0});
		rows.push_back('{32'h00020000, 32'hfffe0000, 32'h7fffffff, 0, '0});
		foreach (rows[i]) send_point(rows[i].px, rows[i].py, rows[i].pz, 0);
		go_quiet();
		foreach (rows[i])
			if (rows[i].check && project_point(rows[i].px, rows[i].py, rows[i].pz) != rows[i].answer) begin
				$error("directed row %0d answer disagrees with prediction", i);
				errors++;
			end
		drain_pipeline();
		write_reg(IDX_VP_SIZE, 32'h0);
		write_reg(IDX_VP_ORIGIN, 32'h80007fff);
		send_point(32'h00030000, 32'h00050000, 32'h00010000, 0);
		send_point(32'h80000000, 32'h7fffffff, 32'h7fffffff, 0);
		go_quiet();
		drain_pipeline();
		write_reg(IDX_VP_SIZE, 32'hffffffff);

		// Random phases with fresh register settings. One phase applies the
		// long hold-off while the sender keeps offering points.
		n = 0;
		for (int phase = 0; n < RANDOM_POINTS; phase++) begin
			write_reg(IDX_ROW0_01, {rand_coef(0), rand_coef(0)});
			write_reg(IDX_ROW0_23, {rand_coef(0), rand_coef(0)});
			write_reg(IDX_ROW1_01, {rand_coef(0), rand_coef(0)});
			write_reg(IDX_ROW1_23, {rand_coef(0), rand_coef(0)});
			write_reg(IDX_ROW3_01, {rand_coef(0), rand_coef(0)});
			write_reg(IDX_ROW3_23, {rand_coef(1), rand_coef(1)});
			case (phase % 4)
				0: write_reg(IDX_VP_SIZE, 32'hffffffff);
				1: write_reg(IDX_VP_SIZE, 32'h0);
				default: write_reg(IDX_VP_SIZE, $urandom());
			endcase
			write_reg(IDX_VP_ORIGIN, (phase % 4 == 0) ? 32'h7fff8000 : $urandom());
			if (phase == 2) fork
				begin
					hold_results = 1;
					repeat (200) @(posedge clk);
					hold_results = 0;
				end
			join_none
			for (int k = 0; k < 150 && n < RANDOM_POINTS; k++, n++)
				send_point(rand_coord(), rand_coord(), rand_coord(), 1);
			go_quiet();
			drain_pipeline();
		end

		drain_pipeline();
		if (errors == 0 && pending_points.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule

### sim.f
sv/ppp_pkg.sv
sv/ppp_transform.sv
sv/ppp_div_cell.sv
sv/ppp_viewport.sv
sv/perspective_point_projection.sv
verif/tb.sv
